[design/teq_pkg.sv]
// Shared types and codes for the timed event queue.
package teq_pkg;

	localparam int TimeW = 32;
	localparam int PayW  = 16;
	localparam int SeqW  = 32;
	localparam int MaxResults = 32;

	localparam logic KindInsert = 1'b0;
	localparam logic KindTick   = 1'b1;

	localparam logic [1:0] StatDue      = 2'd0;
	localparam logic [1:0] StatAccepted = 2'd1;
	localparam logic [1:0] StatDropped  = 2'd2;

	typedef struct packed {
		logic signed [TimeW-1:0] etime;
		logic [PayW-1:0]         payload;
		logic [SeqW-1:0]         seq;
	} entry_t;

	// ins: ordered insert of ent; pop: shift towards the head.
	// ent.etime is also the compare time (due time or current time).
	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t ent;
	} cell_ctrl_t;

endpackage

[design/teq_cell.sv]
// One queue cell: holds one entry, shifts right on insert, left on pop.
module teq_cell
	import teq_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       occ,
	input  entry_t     left_entry,
	input  logic       left_le,
	input  entry_t     right_entry,
	output entry_t     entry,
	output logic       le
);

	entry_t entry_q;

	assign entry = entry_q;
	assign le    = occ && (entry_q.etime <= ctrl.ent.etime);

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!le) begin
				entry_q <= left_le ? ctrl.ent : left_entry;
			end
		end else if (ctrl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

[design/timed_event_queue.sv]
// Top level of the timed event queue: cell chain, sequencer and result register.
//
//   channel | dir | tdata (low bit up)                          | tuser            | tlast
//   s_      | in  | event_time[31:0], payload[15:0]             | kind             | -
//   m_      | out | out_payload[15:0], due_time[31:0], seq[31:0] | status[1:0], late | last
//
// Insert: its result is registered and is offered in the cycle after it is taken.
// Tick: the time is latched, then one due entry per cycle is popped from the
// head cell while the m_ side is not stalled (at most MaxResults per tick), or
// the sequencer returns to idle when nothing is due; a new request waits until done.
// Reset clears the fill count, the sequence counter and the sequencer;
// cell contents are not reset. A stalled m_ side holds the sequencer.
module timed_event_queue
	import teq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // event_time[31:0], payload[47:32]
	input  logic [0:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // out_payload[15:0], due_time[47:16], sequence_res[79:48]
	output logic [2:0]  m_tuser,   // status[1:0], late[2]
	output logic        m_tlast    // last
);

	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam int KW   = $clog2(MaxResults);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t                  state_q;
	logic [CntW-1:0]         count_q;
	logic [SeqW-1:0]         next_seq_q;
	logic signed [TimeW-1:0] tick_time_q;
	logic [KW-1:0]           k_q;

	logic        m_valid_q;
	logic [79:0] m_data_q;
	logic [2:0]  m_user_q;
	logic        m_last_q;

	logic                    out_free;
	logic                    accept;
	logic                    kind_in;
	logic signed [TimeW-1:0] time_in;
	logic [PayW-1:0]         pay_in;
	logic                    full;
	logic                    do_ins;
	logic                    do_pop;
	logic                    pop_last;
	cell_ctrl_t              ctrl;

	entry_t                 cell_entry [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_le;
	logic [QUEUE_DEPTH-1:0] cell_occ;

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign kind_in  = s_tuser[0];
	assign time_in  = s_tdata[31:0];
	assign pay_in   = s_tdata[47:32];
	assign full     = (count_q == CntW'(QUEUE_DEPTH));
	assign do_ins   = accept && (kind_in == KindInsert) && !full;
	assign do_pop   = (state_q == ST_DRAIN) && out_free && cell_le[0];
	assign pop_last = (k_q == KW'(MaxResults - 1)) || (count_q == CntW'(1)) || !cell_le[1];

	always_comb begin
		ctrl.ins         = do_ins;
		ctrl.pop         = do_pop;
		ctrl.ent.etime   = (state_q == ST_IDLE) ? time_in : tick_time_q;
		ctrl.ent.payload = pay_in;
		ctrl.ent.seq     = next_seq_q;
	end

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			assign cell_occ[gi] = (CntW'(gi) < count_q);
			teq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occ         (cell_occ[gi]),
				.left_entry  ((gi == 0) ? ctrl.ent : cell_entry[(gi == 0) ? 0 : gi-1]),
				.left_le     ((gi == 0) ? 1'b1 : cell_le[(gi == 0) ? 0 : gi-1]),
				.right_entry (cell_entry[(gi == QUEUE_DEPTH-1) ? gi : gi+1]),
				.entry       (cell_entry[gi]),
				.le          (cell_le[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			next_seq_q <= '0;
			k_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (accept && (kind_in == KindTick)) begin
						state_q <= ST_DRAIN;
					end
					if (do_ins) begin
						count_q    <= count_q + CntW'(1);
						next_seq_q <= next_seq_q + SeqW'(1);
					end
				end
				ST_DRAIN: begin
					if (out_free) begin
						if (!cell_le[0]) begin
							state_q <= ST_IDLE;
						end else begin
							count_q <= count_q - CntW'(1);
							k_q     <= k_q + KW'(1);
							if (pop_last) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_time_q <= time_in;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (do_pop || (accept && (kind_in == KindInsert))) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			m_data_q <= {cell_entry[0].seq, cell_entry[0].etime, cell_entry[0].payload};
			m_user_q <= {(cell_entry[0].etime < tick_time_q), StatDue};
			m_last_q <= pop_last;
		end else if (accept && (kind_in == KindInsert)) begin
			m_data_q <= {(full ? SeqW'(0) : next_seq_q), time_in, pay_in};
			m_user_q <= {1'b0, (full ? StatDropped : StatAccepted)};
			m_last_q <= 1'b1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QUEUE_DEPTH))
		else $error("fill count beyond depth");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> (count_q == $past(count_q) + CntW'(1)))
		else $error("insert did not advance fill count");

	a_no_take_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> !s_tready)
		else $error("request taken while draining");

	a_pop_due: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |-> (cell_occ[0] && (cell_entry[0].etime <= tick_time_q)))
		else $error("pop of an entry not due");

endmodule
